>>> rtl/complex_arithmetic_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
// Included by the top level; no other dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CAU_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define CAU_ASSERT_RESET(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) else $error("reset check failed");
`else
`define CAU_ASSERT_IMPL(label, clk, rst_n, prop)
`define CAU_ASSERT_RESET(label, clk, cond)
`endif
`endif

>>> rtl/cau_pkg.sv
// Shared types, constants and helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_W = 66;
    localparam int DEN_W = 64;
    localparam int QBITS = 34;
    localparam int DIV_STEPS = NUM_W + FRAC_BITS;
    // quotient magnitude cap: just above 2^32 so the clamp still trips
    localparam logic [QBITS-1:0] QCAP = 34'h100000001;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2, ACT_DIV = 3'd3,
        ACT_CONJ = 3'd4, ACT_NEG = 3'd5, ACT_MOD2 = 3'd6, ACT_NONE = 3'd7
    } action_t;

    typedef struct packed {
        logic                    is_div;
        logic                    dz;
        logic                    direct;
        logic signed [NUM_W-1:0] dre;
        logic signed [NUM_W-1:0] dim;
        logic [NUM_W-1:0]        nre;
        logic [NUM_W-1:0]        nim;
        logic                    sre;
        logic                    sim;
        logic [DEN_W-1:0]        den;
    } cell_t;

    typedef struct packed {
        logic [NUM_W-1:0] rre;
        logic [NUM_W-1:0] rim;
        logic [QBITS-1:0] qre;
        logic [QBITS-1:0] qim;
    } div_t;

    function automatic logic [32:0] clamp(input logic signed [NUM_W-1:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) r = {1'b1, 32'h7FFFFFFF};
        else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction
endpackage

>>> rtl/cau_front.sv
// Input stage: products and sums for every action of the complex arithmetic unit.
// Depends on cau_pkg.
module cau_front (
    input  logic                aclk,
    input  logic                en,
    input  logic [2:0]          action,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output cau_pkg::cell_t      cell_out
);
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0] q_rr_reg, q_ii_reg;
    logic signed [32:0] s_re_reg, s_im_reg;
    logic [2:0]         act_reg;
    logic signed [65:0] x_re, x_im, den_s;
    cau_pkg::cell_t     c;

    // register products (one multiplier each)
    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg  <= action;
            p_rr_reg <= a_re * ((action == cau_pkg::ACT_MOD2) ? a_re : b_re);
            p_ii_reg <= a_im * ((action == cau_pkg::ACT_MOD2) ? a_im : b_im);
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
            q_rr_reg <= b_re * b_re;
            q_ii_reg <= b_im * b_im;
            unique case (action)
                cau_pkg::ACT_ADD: begin
                    s_re_reg <= 33'(a_re) + 33'(b_re);
                    s_im_reg <= 33'(a_im) + 33'(b_im);
                end
                cau_pkg::ACT_SUB: begin
                    s_re_reg <= 33'(a_re) - 33'(b_re);
                    s_im_reg <= 33'(a_im) - 33'(b_im);
                end
                cau_pkg::ACT_CONJ: begin
                    s_re_reg <= 33'(a_re);
                    s_im_reg <= -33'(a_im);
                end
                cau_pkg::ACT_NEG: begin
                    s_re_reg <= -33'(a_re);
                    s_im_reg <= -33'(a_im);
                end
                default: begin
                    s_re_reg <= '0;
                    s_im_reg <= '0;
                end
            endcase
        end
    end

    // combine products into direct results or divider operands
    always_comb begin
        c = '0;
        den_s = 66'(q_rr_reg) + 66'(q_ii_reg);
        unique case (act_reg)
            cau_pkg::ACT_MUL: begin
                x_re = 66'(p_rr_reg) - 66'(p_ii_reg);
                x_im = 66'(p_ri_reg) + 66'(p_ir_reg);
            end
            cau_pkg::ACT_MOD2: begin
                x_re = 66'(p_rr_reg) + 66'(p_ii_reg);
                x_im = '0;
            end
            cau_pkg::ACT_DIV: begin
                x_re = 66'(p_rr_reg) + 66'(p_ii_reg);
                x_im = 66'(p_ir_reg) - 66'(p_ri_reg);
            end
            default: begin
                x_re = 66'(s_re_reg);
                x_im = 66'(s_im_reg);
            end
        endcase
        c.direct = (act_reg != cau_pkg::ACT_DIV);
        c.is_div = (act_reg == cau_pkg::ACT_DIV);
        if (act_reg == cau_pkg::ACT_MUL || act_reg == cau_pkg::ACT_MOD2) begin
            c.dre = x_re >>> cau_pkg::FRAC_BITS;
            c.dim = x_im >>> cau_pkg::FRAC_BITS;
        end else begin
            c.dre = x_re;
            c.dim = x_im;
        end
        c.sre = x_re[65];
        c.sim = x_im[65];
        c.nre = x_re[65] ? -x_re : x_re;
        c.nim = x_im[65] ? -x_im : x_im;
        c.den = den_s[63:0];
        c.dz  = c.is_div && (den_s == '0);
    end

    assign cell_out = c;
endmodule

>>> rtl/cau_div_cell.sv
// One restoring-division cell: shifts one numerator bit into both remainders.
// Depends on cau_pkg.
module cau_div_cell (
    input  logic            aclk,
    input  logic            en,
    input  logic            valid_in,
    input  logic [6:0]      step,
    input  cau_pkg::cell_t  cell_in,
    input  cau_pkg::div_t   div_in,
    output logic            valid_out,
    output cau_pkg::cell_t  cell_out,
    output cau_pkg::div_t   div_out
);
    logic [66:0]   tre, tim;
    logic [33:0]   qre, qim;
    logic          bre, bim;
    cau_pkg::div_t d;
    logic          v_reg;
    cau_pkg::cell_t c_reg;
    cau_pkg::div_t  d_reg;

    // numerator bit: n << FRAC_BITS, MSB first
    always_comb begin
        if (step >= 7'(cau_pkg::FRAC_BITS)) begin
            bre = cell_in.nre[7'(step - 7'(cau_pkg::FRAC_BITS))];
            bim = cell_in.nim[7'(step - 7'(cau_pkg::FRAC_BITS))];
        end else begin
            bre = 1'b0;
            bim = 1'b0;
        end
        tre = {div_in.rre, bre};
        tim = {div_in.rim, bim};
        qre = {div_in.qre[32:0], 1'b0};
        qim = {div_in.qim[32:0], 1'b0};
        d = div_in;
        if (tre >= 67'(cell_in.den)) begin
            tre = tre - 67'(cell_in.den);
            qre[0] = 1'b1;
        end
        if (tim >= 67'(cell_in.den)) begin
            tim = tim - 67'(cell_in.den);
            qim[0] = 1'b1;
        end
        if (qre > 34'h100000000) qre = cau_pkg::QCAP;
        if (qim > 34'h100000000) qim = cau_pkg::QCAP;
        d.rre = tre[65:0];
        d.rim = tim[65:0];
        d.qre = qre;
        d.qim = qim;
    end

    // advance to the next cell
    always_ff @(posedge aclk) begin
        if (!en) begin
        end else begin
            v_reg <= valid_in;
            c_reg <= cell_in;
            d_reg <= (cell_in.is_div && !cell_in.dz) ? d : div_in;
        end
    end

    assign valid_out = v_reg;
    assign cell_out  = c_reg;
    assign div_out   = d_reg;
endmodule

>>> rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: front stage, chain of division cells, output.
// Depends on cau_pkg, cau_front, cau_div_cell and the macro header.
//
//  channel | dir | tdata (low bit up)                      | tuser
//  s_      | in  | action[2:0] a_re a_im b_re b_im (136 b)  | -
//  m_      | out | res_re res_im (64 b)                     | divide_by_zero, saturated
//
// Pipeline: 84 stages (product register, 82 cells, one per quotient bit, output register).
// One item per cycle; the whole pipeline advances when the output is free.
// Reset (aresetn low, synchronous) clears the valid bits of all stages.
// A stall on m_tready holds every stage.
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // action, a_re, a_im, b_re, b_im
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [1:0]   m_tuser    // divide_by_zero, saturated
);
    logic             en;
    logic             v1_reg;
    cau_pkg::cell_t   cells [cau_pkg::DIV_STEPS+1];
    cau_pkg::div_t    divs  [cau_pkg::DIV_STEPS+1];
    logic             vals  [cau_pkg::DIV_STEPS+1];
    logic [32:0]      cre, cim;
    logic signed [65:0] fre, fim;

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .aclk(aclk), .en(en), .action(s_tdata[2:0]),
        .a_re(s_tdata[34:3]), .a_im(s_tdata[66:35]),
        .b_re(s_tdata[98:67]), .b_im(s_tdata[130:99]),
        .cell_out(cells[0])
    );

    // track the front stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_tvalid;
    end
    assign vals[0] = v1_reg;
    assign divs[0] = '0;

    // chain of cells, one quotient bit each
    for (genvar g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_cell
        logic vo;
        cau_div_cell u_cell (
            .aclk(aclk), .en(en), .valid_in(vals[g]),
            .step(7'(cau_pkg::DIV_STEPS - 1 - g)), .cell_in(cells[g]), .div_in(divs[g]),
            .valid_out(vo), .cell_out(cells[g+1]), .div_out(divs[g+1])
        );
        logic v_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg <= 1'b0;
            else if (en) v_reg <= vals[g];
        end
        assign vals[g+1] = v_reg & vo;
    end

    // final sign, clamp and output register
    always_comb begin
        fre = cells[cau_pkg::DIV_STEPS].sre ? -66'(divs[cau_pkg::DIV_STEPS].qre)
                                            : 66'(divs[cau_pkg::DIV_STEPS].qre);
        fim = cells[cau_pkg::DIV_STEPS].sim ? -66'(divs[cau_pkg::DIV_STEPS].qim)
                                            : 66'(divs[cau_pkg::DIV_STEPS].qim);
        if (cells[cau_pkg::DIV_STEPS].direct) begin
            cre = cau_pkg::clamp(cells[cau_pkg::DIV_STEPS].dre);
            cim = cau_pkg::clamp(cells[cau_pkg::DIV_STEPS].dim);
        end else if (cells[cau_pkg::DIV_STEPS].dz) begin
            cre = '0;
            cim = '0;
        end else begin
            cre = cau_pkg::clamp(fre);
            cim = cau_pkg::clamp(fim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (en) m_tvalid <= vals[cau_pkg::DIV_STEPS];
        if (en) begin
            m_tdata <= {cim[31:0], cre[31:0]};
            m_tuser <= {cre[32] | cim[32], cells[cau_pkg::DIV_STEPS].dz};
        end
    end

    `CAU_ASSERT_IMPL(a_ready, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `CAU_ASSERT_IMPL(a_dz_zero, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    `CAU_ASSERT_IMPL(a_dz_nosat, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
    `CAU_ASSERT_RESET(a_rst, aclk, !aresetn |=> !m_tvalid)
endmodule
